>>> rtl/core/epoch_seconds_to_calendar_date_assert.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// same-cycle implication
`define E2C_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("e2c assertion failed");

// next-cycle implication
`define E2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("e2c assertion failed");

`endif

>>> rtl/core/e2c_pkg.sv
// shared constants, types and month table for the seconds to date converter
// no dependencies
package e2c_pkg;

  localparam int unsigned E2C_STAGES = 7;

  localparam int unsigned YEAR_W   = 11;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned DOY_W    = 9;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1904;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } e2c_date_t;

  // first day of month idx (0 based) within the year
  function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] base;
    logic             adj;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    adj = leap && (idx >= 4'd2);
    return base + {8'd0, adj};
  endfunction

endpackage

>>> rtl/core/e2c_month.sv
// month and day of month from day of year and leap flag
// depends on e2c_pkg
module e2c_month (
  input  logic [e2c_pkg::DOY_W-1:0] doy,
  input  logic                      leap,
  output e2c_pkg::e2c_date_t        date
);
  import e2c_pkg::*;

  logic [MONTH_W-1:0] idx;
  logic [DOY_W-1:0]   start;
  logic [DOY_W-1:0]   dom;

  always_comb begin
    idx = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= month_start(leap, MONTH_W'(k))) begin
        idx = MONTH_W'(k);
      end
    end
    start      = month_start(leap, idx);
    dom        = doy - start + 9'd1;
    date.month = idx + 4'd1;
    date.day   = dom[DAY_W-1:0];
  end

endmodule

>>> rtl/core/epoch_seconds_to_calendar_date.sv
// seconds since 1904-01-01 to calendar date and time of day, top level
// depends on e2c_pkg and e2c_month
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[31:0] seconds
//  out_    | out | out_tvalid/tready  | tdata year,month,day,hour,minute,second
//
// seven register stages, one item per cycle while out_tready does not stall the output
// the constant reciprocal multiplies set the stage boundaries, at most one deep per stage
// each stage takes a new item when empty or when the stage after it moves
// rst_n clears all stage valid bits; payload registers are not reset
module epoch_seconds_to_calendar_date (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [e2c_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] seconds
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [10:0] year, [14:11] month, [19:15] day, [24:20] hour, [30:25] minute,
  // [36:31] second_of_minute, [39:37] zero
  output logic [e2c_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import e2c_pkg::*;

  logic [E2C_STAGES-1:0] v_r;
  logic [E2C_STAGES-1:0] v_nxt;
  logic [E2C_STAGES-1:0] rdy;

  // stage 1
  logic [31:0]           secs1_r;
  // stage 2
  logic [15:0]           days2_r;
  logic [31:0]           secs2_r;
  // stage 3
  logic [16:0]           tod3_r;
  logic [5:0]            cyc3_r;
  logic [15:0]           days3_r;
  // stage 4
  logic [10:0]           dic4_r;
  logic [HOUR_W-1:0]     hour4_r;
  logic [16:0]           tod4_r;
  logic [5:0]            cyc4_r;
  // stage 5
  logic [11:0]           rem5_r;
  logic [1:0]            yic5_r;
  logic [DOY_W-1:0]      doy5_r;
  logic                  leap5_r;
  logic [HOUR_W-1:0]     hour5_r;
  logic [5:0]            cyc5_r;
  // stage 6
  logic [MINUTE_W-1:0]   min6_r;
  logic [11:0]           rem6_r;
  e2c_date_t             date6_r;
  logic [YEAR_W-1:0]     year6_r;
  logic [HOUR_W-1:0]     hour6_r;
  // stage 7, output register
  logic [MINUTE_W-1:0]   min7_r;
  logic [SECOND_W-1:0]   sec7_r;
  e2c_date_t             date7_r;
  logic [YEAR_W-1:0]     year7_r;
  logic [HOUR_W-1:0]     hour7_r;

  logic [50:0]           dprod;
  logic [15:0]           days_nxt;
  logic [32:0]           dsec;
  logic [32:0]           cprod;
  logic [16:0]           tod_nxt;
  logic [5:0]            cyc_nxt;
  logic [16:0]           yprod;
  logic [10:0]           dic_nxt;
  logic [34:0]           hprod;
  logic [HOUR_W-1:0]     hour_nxt;
  logic [16:0]           hsec;
  logic [11:0]           rem_nxt;
  logic [1:0]            yic_nxt;
  logic [10:0]           doy_full;
  logic [DOY_W-1:0]      doy_nxt;
  logic [24:0]           mprod;
  logic [MINUTE_W-1:0]   min_nxt;
  logic [YEAR_W-1:0]     year_nxt;
  e2c_date_t             date_nxt;
  logic [11:0]           msec;
  logic [11:0]           sec_full;
  logic [SECOND_W-1:0]   sec_nxt;

  // stage handshake chain
  always_comb begin
    rdy[E2C_STAGES-1] = !v_r[E2C_STAGES-1] || out_tready;
    for (int k = E2C_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < E2C_STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // days = secs / 86400 as (secs >> 7) / 675 by reciprocal
  assign dprod    = {26'd0, secs1_r[31:7]} * 51'd50903317;
  assign days_nxt = dprod[50:35];

  // time of day and four-year cycle
  assign dsec    = days2_r * 17'd86400;
  assign tod_nxt = 17'(secs2_r - dsec[31:0]);
  assign cprod   = days2_r * 17'd91868;
  assign cyc_nxt = cprod[32:27];

  // day in cycle and hour
  assign yprod    = cyc3_r * 11'd1461;
  assign dic_nxt  = 11'(days3_r - yprod[15:0]);
  assign hprod    = tod3_r * 18'd149131;
  assign hour_nxt = hprod[33:29];

  // seconds in hour, year in cycle and day of year
  assign hsec    = hour4_r * 12'd3600;
  assign rem_nxt = 12'(tod4_r - hsec);

  always_comb begin
    if (dic4_r < 11'd366) begin
      yic_nxt  = 2'd0;
      doy_full = dic4_r;
    end else if (dic4_r < 11'd731) begin
      yic_nxt  = 2'd1;
      doy_full = dic4_r - 11'd366;
    end else if (dic4_r < 11'd1096) begin
      yic_nxt  = 2'd2;
      doy_full = dic4_r - 11'd731;
    end else begin
      yic_nxt  = 2'd3;
      doy_full = dic4_r - 11'd1096;
    end
  end
  assign doy_nxt = doy_full[DOY_W-1:0];

  // minute, month, day and year
  assign mprod    = rem5_r * 13'd4370;
  assign min_nxt  = mprod[23:18];
  assign year_nxt = EPOCH_YEAR + {3'd0, cyc5_r, 2'b00} + {9'd0, yic5_r};

  e2c_month u_month (
    .doy  (doy5_r),
    .leap (leap5_r),
    .date (date_nxt)
  );

  // second of minute
  assign msec     = min6_r * 6'd60;
  assign sec_full = rem6_r - msec;
  assign sec_nxt  = sec_full[SECOND_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      secs1_r <= in_tdata;
    end
    if (rdy[1]) begin
      days2_r <= days_nxt;
      secs2_r <= secs1_r;
    end
    if (rdy[2]) begin
      tod3_r  <= tod_nxt;
      cyc3_r  <= cyc_nxt;
      days3_r <= days2_r;
    end
    if (rdy[3]) begin
      dic4_r  <= dic_nxt;
      hour4_r <= hour_nxt;
      tod4_r  <= tod3_r;
      cyc4_r  <= cyc3_r;
    end
    if (rdy[4]) begin
      rem5_r  <= rem_nxt;
      yic5_r  <= yic_nxt;
      doy5_r  <= doy_nxt;
      leap5_r <= (yic_nxt == 2'd0);
      hour5_r <= hour4_r;
      cyc5_r  <= cyc4_r;
    end
    if (rdy[5]) begin
      min6_r  <= min_nxt;
      rem6_r  <= rem5_r;
      date6_r <= date_nxt;
      year6_r <= year_nxt;
      hour6_r <= hour5_r;
    end
    if (rdy[6]) begin
      min7_r  <= min6_r;
      sec7_r  <= sec_nxt;
      date7_r <= date6_r;
      year7_r <= year6_r;
      hour7_r <= hour6_r;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[E2C_STAGES-1];
  assign out_tdata  = {3'd0, sec7_r, min7_r, hour7_r, date7_r.day, date7_r.month, year7_r};

endmodule

>>> rtl/core/e2c_checker.sv
// port-level checks for the seconds to date converter, bound to the top level
// depends on e2c_pkg and epoch_seconds_to_calendar_date_assert.svh
`include "epoch_seconds_to_calendar_date_assert.svh"

module e2c_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [e2c_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import e2c_pkg::*;

  logic fields_in_range;

  assign fields_in_range =
    (out_tdata[10:0] >= 11'd1904) && (out_tdata[10:0] <= 11'd2040) &&
    (out_tdata[14:11] >= 4'd1) && (out_tdata[14:11] <= 4'd12) &&
    (out_tdata[19:15] >= 5'd1) && (out_tdata[24:20] <= 5'd23) &&
    (out_tdata[30:25] <= 6'd59) && (out_tdata[36:31] <= 6'd59);

  // a held result stays offered
  `E2C_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // a held result keeps its value
  `E2C_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // a draining output never blocks the input side
  `E2C_ASSERT_IMP(a_in_flows, out_tready, in_tready)

  // every offered date and time is in range
  `E2C_ASSERT_IMP(a_fields_ok, out_tvalid, fields_in_range)

endmodule

bind epoch_seconds_to_calendar_date e2c_checker u_e2c_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/epoch_seconds_to_calendar_date_test.sv
// testbench for epoch_seconds_to_calendar_date: drives timestamps and checks every date
// and time of day against a predictor built into a small scoreboard class
// depends on e2c_pkg and the epoch_seconds_to_calendar_date rtl
module epoch_seconds_to_calendar_date_test;
  import e2c_pkg::*;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned DAYS_PER_CYCLE = 1461;
  localparam int unsigned LEAP_YEAR_DAYS = 366;
  localparam int unsigned NORM_YEAR_DAYS = 365;
  localparam int unsigned BASE_YEAR      = 1904;
  localparam int unsigned LAST_YEAR      = 2040;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned CHUNK_ITEMS    = 50;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second_of_minute;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t expected_dates[$];
    int        mismatches = 0;

    function int unsigned month_length(bit leap, int unsigned idx);
      int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      return lens[idx] + ((leap && idx == 1) ? 1 : 0);
    endfunction

    function calendar_t to_calendar(logic [IN_TDATA_W-1:0] secs);
      int unsigned days, tod, dic, yic, doy, m;
      bit          leap;
      calendar_t   c;
      days = secs / SECS_PER_DAY;
      tod  = secs % SECS_PER_DAY;
      dic  = days % DAYS_PER_CYCLE;
      if (dic < LEAP_YEAR_DAYS) begin
        yic  = 0;
        doy  = dic;
        leap = 1;
      end else begin
        yic  = 1 + (dic - LEAP_YEAR_DAYS) / NORM_YEAR_DAYS;
        doy  = (dic - LEAP_YEAR_DAYS) % NORM_YEAR_DAYS;
        leap = 0;
      end
      m = 0;
      while (m < 11 && doy >= month_length(leap, m)) begin
        doy -= month_length(leap, m);
        m++;
      end
      c.year             = YEAR_W'(BASE_YEAR + 4 * (days / DAYS_PER_CYCLE) + yic);
      c.month            = MONTH_W'(m + 1);
      c.day              = DAY_W'(doy + 1);
      c.hour             = HOUR_W'(tod / SECS_PER_HOUR);
      c.minute           = MINUTE_W'((tod % SECS_PER_HOUR) / 60);
      c.second_of_minute = SECOND_W'(tod % 60);
      return c;
    endfunction

    function void note_seconds(logic [IN_TDATA_W-1:0] secs);
      expected_dates.push_back(to_calendar(secs));
    endfunction

    function bit field_ok(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s: expected %0d, got %0d", name, exp, got);
        return 0;
      end
      return 1;
    endfunction

    function void check_date(logic [OUT_TDATA_W-1:0] tdata);
      calendar_t exp;
      bit        ok;
      if (expected_dates.size() == 0) begin
        $error("result with no timestamp outstanding: %h", tdata);
        mismatches++;
        return;
      end
      exp = expected_dates.pop_front();
      ok = field_ok("year", exp.year, tdata[10:0]);
      ok = field_ok("month", exp.month, tdata[14:11]) && ok;
      ok = field_ok("day", exp.day, tdata[19:15]) && ok;
      ok = field_ok("hour", exp.hour, tdata[24:20]) && ok;
      ok = field_ok("minute", exp.minute, tdata[30:25]) && ok;
      ok = field_ok("second_of_minute", exp.second_of_minute, tdata[36:31]) && ok;
      if (!ok) mismatches++;
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  calendar_scoreboard dates = new();
  bit                 steady = 0;
  bit                 hold_request = 0;

  always #5 clk = ~clk;

  epoch_seconds_to_calendar_date dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // day number of the first of month m (0 based) in year base+y
  function automatic longint first_of_month(int unsigned y, int unsigned m);
    longint d;
    d = (y / 4) * DAYS_PER_CYCLE;
    if (y % 4 != 0) d += LEAP_YEAR_DAYS + (y % 4 - 1) * NORM_YEAR_DAYS;
    for (int unsigned i = 0; i < m; i++) d += dates.month_length(y % 4 == 0, i);
    return d;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_seconds();
    longint s;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    s = first_of_month($urandom_range(0, LAST_YEAR - BASE_YEAR), $urandom_range(0, 11))
        * SECS_PER_DAY;
    case ($urandom_range(0, 3))
      0: s -= 1;
      1: s += 0;
      2: s += $urandom_range(1, 59);
      default: s += $urandom_range(0, SECS_PER_DAY - 1);
    endcase
    if (s < 0 || s > 64'hFFFF_FFFF) return $urandom;
    return IN_TDATA_W'(s);
  endfunction

  task automatic send_seconds(logic [IN_TDATA_W-1:0] secs, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
    dates.note_seconds(secs);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (dates.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) dates.check_date(out_tdata);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        hold_left = pick_gap();
        out_tready <= 1'b0;
      end
    end
  end

  initial begin
    logic [IN_TDATA_W-1:0] directed[$];
    directed = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
      SECS_PER_DAY - 1, SECS_PER_DAY,
      59 * SECS_PER_DAY - 1, 59 * SECS_PER_DAY, 60 * SECS_PER_DAY,
      LEAP_YEAR_DAYS * SECS_PER_DAY - 1, LEAP_YEAR_DAYS * SECS_PER_DAY,
      (LEAP_YEAR_DAYS + 59) * SECS_PER_DAY,
      (LEAP_YEAR_DAYS + NORM_YEAR_DAYS) * SECS_PER_DAY - 1,
      (LEAP_YEAR_DAYS + NORM_YEAR_DAYS) * SECS_PER_DAY,
      DAYS_PER_CYCLE * SECS_PER_DAY - 1, DAYS_PER_CYCLE * SECS_PER_DAY,
      (24 * DAYS_PER_CYCLE + 59) * SECS_PER_DAY,
      (24 * DAYS_PER_CYCLE + 60) * SECS_PER_DAY - 1,
      34 * DAYS_PER_CYCLE * SECS_PER_DAY,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_seconds(directed[i], pick_gap());
    drain();

    // long receiver hold while items keep coming, fills the pipeline
    hold_request = 1;
    repeat (40) send_seconds(random_seconds(), 0);
    drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / CHUNK_ITEMS) % 3 == 2);
      send_seconds(random_seconds(), steady ? 0 : pick_gap());
    end
    drain();
    steady = 0;
    repeat (2 * E2C_STAGES + 4) @(posedge clk);

    if (dates.mismatches == 0 && dates.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
